### hdl/trilinear_poly_eval_and_rate_macros.svh
// Assertion macros shared by the checker of the trilinear evaluator.
`ifndef TRILINEAR_POLY_EVAL_AND_RATE_MACROS_SVH
`define TRILINEAR_POLY_EVAL_AND_RATE_MACROS_SVH

// Implication checked on every clock, off while reset is low.
`define TPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define TPE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/tpe_pkg.sv
// Types, constants and arithmetic helpers of the trilinear evaluator.
package tpe_pkg;

    localparam int TPE_WORD_BITS = 32;
    localparam int TPE_FRAC_BITS = 16;
    localparam int TPE_CFG_IDX_W = 4;
    // pair products, triple products, partial sum, rate limbs,
    // limb sum, rounding add, saturation
    localparam int TPE_LATENCY   = 7;

    typedef logic signed [TPE_WORD_BITS-1:0]   tpe_word_t;
    typedef logic signed [2*TPE_WORD_BITS-1:0] tpe_pair_t;
    typedef logic signed [TPE_WORD_BITS:0]     tpe_limb_t;
    typedef logic signed [2*TPE_WORD_BITS:0]   tpe_prod_t;

    localparam tpe_word_t TPE_WORD_MAX = {1'b0, {(TPE_WORD_BITS-1){1'b1}}};
    localparam tpe_word_t TPE_WORD_MIN = {1'b1, {(TPE_WORD_BITS-1){1'b0}}};

    typedef enum logic {
        TPE_MODE_VALUE = 1'b0,
        TPE_MODE_RATE  = 1'b1
    } tpe_mode_t;

    typedef enum logic [TPE_CFG_IDX_W-1:0] {
        TPE_REG_CONST = 4'd0,
        TPE_REG_X     = 4'd1,
        TPE_REG_Y     = 4'd2,
        TPE_REG_Z     = 4'd3,
        TPE_REG_XY    = 4'd4,
        TPE_REG_XZ    = 4'd5,
        TPE_REG_YZ    = 4'd6,
        TPE_REG_XYZ   = 4'd7
    } tpe_reg_idx_t;

    typedef struct packed {
        logic      mode;
        tpe_word_t in_x;
        tpe_word_t in_y;
        tpe_word_t in_z;
        tpe_word_t rate_x;
        tpe_word_t rate_y;
        tpe_word_t rate_z;
    } tpe_item_t;

    typedef struct packed {
        tpe_word_t result;
        logic      saturated;
    } tpe_res_t;

    // One lane: d = clin<<2F + (ca*va + cb*vb)<<F + ctri*va*vb,
    // then u*d, or d<<F when lsh is set.
    typedef struct packed {
        tpe_word_t clin;
        tpe_word_t ca;
        tpe_word_t va;
        tpe_word_t cb;
        tpe_word_t vb;
        tpe_word_t ctri;
        tpe_word_t u;
        logic      lsh;
    } tpe_lane_op_t;

    // Load enables of the pipeline stages, one per register stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } tpe_stage_en_t;

    function automatic int tpe_mag_bits(int frac);
        return (TPE_WORD_BITS - 1 > frac) ? TPE_WORD_BITS - 1 : frac;
    endfunction

    // width of a lane's partial derivative term
    function automatic int tpe_d_w(int frac);
        return 3 * tpe_mag_bits(frac) + 4;
    endfunction

    // width of the exact sum of all terms
    function automatic int tpe_acc_w(int frac);
        return 4 * tpe_mag_bits(frac) + 7;
    endfunction

    function automatic tpe_pair_t tpe_mul_ww(tpe_word_t a, tpe_word_t b);
        return tpe_pair_t'(a) * tpe_pair_t'(b);
    endfunction

    function automatic tpe_prod_t tpe_mul_wl(tpe_word_t a, tpe_limb_t b);
        return tpe_prod_t'(a) * tpe_prod_t'(b);
    endfunction

endpackage

### hdl/tpe_lane.sv
// One multiply lane: partial derivative term and its product with a rate.
module tpe_lane
    import tpe_pkg::*;
#(
    parameter int FRAC_BITS = TPE_FRAC_BITS
)
(
    input  logic                                  clk,
    input  tpe_stage_en_t                         en,
    input  tpe_lane_op_t                          op,
    output logic signed [tpe_acc_w(FRAC_BITS)-1:0] total
);

    localparam int W  = TPE_WORD_BITS;
    localparam int DW = tpe_d_w(FRAC_BITS);
    localparam int AW = tpe_acc_w(FRAC_BITS);
    localparam int NL = (DW + W - 1) / W;
    localparam int F2 = 2 * FRAC_BITS;

    // stage 1: pair products
    tpe_pair_t pa_reg, pb_reg, vv_reg;
    tpe_word_t clin1_reg, ctri1_reg, u1_reg;
    logic      lsh1_reg;

    // stage 2: triple product in two limbs, pair sum
    tpe_prod_t pl_reg, ph_reg, psum_reg;
    tpe_word_t clin2_reg, u2_reg;
    logic      lsh2_reg;
    tpe_prod_t pl_next, ph_next, psum_next;

    // stage 3: partial derivative term
    logic signed [DW-1:0] d_reg, d_next;
    tpe_word_t            u3_reg;
    logic                 lsh3_reg;

    // stage 4: rate times each limb of d
    logic signed [NL*W-1:0] dpad;
    tpe_limb_t              limb [NL];
    tpe_prod_t              prt_next [NL];
    tpe_prod_t              prt_reg [NL];
    logic signed [DW-1:0]   d4_reg;
    logic                   lsh4_reg;

    // stage 5: lane total
    logic signed [AW-1:0] tot_reg, tot_next;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pa_reg    <= tpe_mul_ww(op.ca, op.va);
            pb_reg    <= tpe_mul_ww(op.cb, op.vb);
            vv_reg    <= tpe_mul_ww(op.va, op.vb);
            clin1_reg <= op.clin;
            ctri1_reg <= op.ctri;
            u1_reg    <= op.u;
            lsh1_reg  <= op.lsh;
        end
    end

    // low limb unsigned, high limb signed
    assign pl_next   = tpe_mul_wl(ctri1_reg, tpe_limb_t'({1'b0, vv_reg[W-1:0]}));
    assign ph_next   = tpe_mul_wl(ctri1_reg, tpe_limb_t'({vv_reg[2*W-1], vv_reg[2*W-1:W]}));
    assign psum_next = tpe_prod_t'(pa_reg) + tpe_prod_t'(pb_reg);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            psum_reg  <= psum_next;
            clin2_reg <= clin1_reg;
            u2_reg    <= u1_reg;
            lsh2_reg  <= lsh1_reg;
        end
    end

    assign d_next = (DW'(clin2_reg) <<< F2) + (DW'(psum_reg) <<< FRAC_BITS)
                  + (DW'(ph_reg) <<< W) + DW'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            d_reg    <= d_next;
            u3_reg   <= u2_reg;
            lsh3_reg <= lsh2_reg;
        end
    end

    assign dpad = (NL*W)'(d_reg);

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            if (k == NL - 1)
                limb[k] = tpe_limb_t'({dpad[NL*W-1], dpad[k*W +: W]});
            else
                limb[k] = tpe_limb_t'({1'b0, dpad[k*W +: W]});
            prt_next[k] = tpe_mul_wl(u3_reg, limb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            for (int k = 0; k < NL; k++)
                prt_reg[k] <= prt_next[k];
            d4_reg   <= d_reg;
            lsh4_reg <= lsh3_reg;
        end
    end

    always_comb
    begin
        tot_next = '0;
        if (lsh4_reg)
            tot_next = AW'(d4_reg) <<< FRAC_BITS;
        else
            for (int k = 0; k < NL; k++)
                tot_next = tot_next + (AW'(prt_reg[k]) <<< (k*W));
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
            tot_reg <= tot_next;
    end

    assign total = tot_reg;

endmodule

### hdl/tpe_round.sv
// Final sum of the lanes, rounding to the output scale and saturation.
module tpe_round
    import tpe_pkg::*;
#(
    parameter int FRAC_BITS = TPE_FRAC_BITS
)
(
    input  logic                                   clk,
    input  tpe_stage_en_t                          en,
    input  logic signed [tpe_acc_w(FRAC_BITS)-1:0] t0,
    input  logic signed [tpe_acc_w(FRAC_BITS)-1:0] t1,
    input  logic signed [tpe_acc_w(FRAC_BITS)-1:0] t2,
    output tpe_res_t                               res
);

    localparam int W   = TPE_WORD_BITS;
    localparam int AW  = tpe_acc_w(FRAC_BITS);
    localparam int SH3 = 3 * FRAC_BITS;
    localparam int HB  = (SH3 > 0) ? SH3 - 1 : 0;
    localparam logic signed [AW-1:0] HALF = (SH3 > 0) ? (AW'(1) <<< HB) : '0;

    logic signed [AW-1:0]     sum_reg, sum_next;
    logic signed [AW-1:0]     shv;
    logic [AW-SH3-1:W-1]      hi;
    logic                     over;
    tpe_res_t                 res_reg, res_next;

    // round half up: add half an output LSB before the arithmetic shift
    assign sum_next = t0 + t1 + t2 + HALF;

    always_ff @(posedge clk)
    begin
        if (en.s6)
            sum_reg <= sum_next;
    end

    assign shv  = sum_reg >>> SH3;
    assign hi   = shv[AW-SH3-1:W-1];
    assign over = !((&hi) || !(|hi));

    always_comb
    begin
        res_next.saturated = over;
        if (!over)
            res_next.result = shv[W-1:0];
        else if (shv[AW-1])
            res_next.result = TPE_WORD_MIN;
        else
            res_next.result = TPE_WORD_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en.s7)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### hdl/trilinear_poly_eval_and_rate.sv
// Top level of the trilinear polynomial evaluator with time-derivative mode.
//
// Fully pipelined: one item is taken in every clock cycle and its result
// shows on res with done high for one cycle when the accepted beat (start
// high while busy is low) reaches the end of the pipe. busy never rises, so
// start may stay high for a continuous stream. Each beat runs through the
// seven register stages of the multiplier datapath: pair products, triple
// product limbs, partial-derivative sum, rate times derivative limbs, limb
// sum, rounding add, and saturation into the output register. The receiver
// cannot stall; a result not taken in its cycle is gone. Coefficients are
// written through the cfg channel (cfg_ready is always high), index 0 to 7
// in the order const, x, y, z, xy, xz, yz, xyz; other indexes are dropped.
// Write them only while no item is in flight.
//
// Datapath: three lanes each build d = c + (ca*a + cb*b) + ctri*a*b at three
// times the fraction scale. In derivative mode these are dp/dx, dp/dy and
// dp/dz and each is multiplied by its rate. In value mode lane x carries
// dp/dx times x, lane y carries the x-free part of p, and lane z is zeroed.
// All sums are exact; the total is rounded half up once and saturated.
module trilinear_poly_eval_and_rate
    import tpe_pkg::*;
#(
    parameter int FRAC_BITS = TPE_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  tpe_item_t                item,
    output logic                     done,
    output tpe_res_t                 res,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TPE_CFG_IDX_W-1:0] cfg_index,
    input  tpe_word_t                cfg_data
);

    localparam int AW = tpe_acc_w(FRAC_BITS);

    typedef struct packed {
        tpe_word_t c0;
        tpe_word_t cx;
        tpe_word_t cy;
        tpe_word_t cz;
        tpe_word_t cxy;
        tpe_word_t cxz;
        tpe_word_t cyz;
        tpe_word_t cxyz;
    } tpe_coef_t;

    tpe_coef_t              coef_reg, coef_next;
    logic [TPE_LATENCY-1:0] vld_reg, vld_next;
    logic                   accept;
    logic                   rate_mode;
    tpe_stage_en_t          en;
    tpe_lane_op_t           op_x, op_y, op_z;
    logic signed [AW-1:0]   tot_x, tot_y, tot_z;

    // never stalls: a stage loads whenever a valid beat reaches it
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // coefficient register file
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                TPE_REG_CONST: coef_next.c0   = cfg_data;
                TPE_REG_X:     coef_next.cx   = cfg_data;
                TPE_REG_Y:     coef_next.cy   = cfg_data;
                TPE_REG_Z:     coef_next.cz   = cfg_data;
                TPE_REG_XY:    coef_next.cxy  = cfg_data;
                TPE_REG_XZ:    coef_next.cxz  = cfg_data;
                TPE_REG_YZ:    coef_next.cyz  = cfg_data;
                TPE_REG_XYZ:   coef_next.cxyz = cfg_data;
                default:       ;
            endcase
        end
    end

    // valid bits follow the beat down the pipe
    assign vld_next = {vld_reg[TPE_LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            vld_reg  <= vld_next;
        end
    end

    assign en.s1 = accept;
    assign en.s2 = vld_reg[0];
    assign en.s3 = vld_reg[1];
    assign en.s4 = vld_reg[2];
    assign en.s5 = vld_reg[3];
    assign en.s6 = vld_reg[4];
    assign en.s7 = vld_reg[5];
    assign done  = vld_reg[TPE_LATENCY-1];

    assign rate_mode = (item.mode == TPE_MODE_RATE);

    // operand steering per mode
    always_comb
    begin
        // dp/dx in both modes; times x for the value, rate_x for the rate
        op_x.clin = coef_reg.cx;
        op_x.ca   = coef_reg.cxy;
        op_x.va   = item.in_y;
        op_x.cb   = coef_reg.cxz;
        op_x.vb   = item.in_z;
        op_x.ctri = coef_reg.cxyz;
        op_x.u    = rate_mode ? item.rate_x : item.in_x;
        op_x.lsh  = 1'b0;

        // dp/dy, or in value mode the terms free of x, aligned by a shift
        op_y.u = item.rate_y;
        if (rate_mode)
        begin
            op_y.clin = coef_reg.cy;
            op_y.ca   = coef_reg.cxy;
            op_y.va   = item.in_x;
            op_y.cb   = coef_reg.cyz;
            op_y.vb   = item.in_z;
            op_y.ctri = coef_reg.cxyz;
            op_y.lsh  = 1'b0;
        end
        else
        begin
            op_y.clin = coef_reg.c0;
            op_y.ca   = coef_reg.cy;
            op_y.va   = item.in_y;
            op_y.cb   = coef_reg.cz;
            op_y.vb   = item.in_z;
            op_y.ctri = coef_reg.cyz;
            op_y.lsh  = 1'b1;
        end

        // dp/dz, weight forced to zero in value mode
        op_z.clin = coef_reg.cz;
        op_z.ca   = coef_reg.cxz;
        op_z.va   = item.in_x;
        op_z.cb   = coef_reg.cyz;
        op_z.vb   = item.in_y;
        op_z.ctri = coef_reg.cxyz;
        op_z.u    = rate_mode ? item.rate_z : '0;
        op_z.lsh  = 1'b0;
    end

    tpe_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_x (
        .clk   (clk),
        .en    (en),
        .op    (op_x),
        .total (tot_x)
    );

    tpe_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_y (
        .clk   (clk),
        .en    (en),
        .op    (op_y),
        .total (tot_y)
    );

    tpe_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_z (
        .clk   (clk),
        .en    (en),
        .op    (op_z),
        .total (tot_z)
    );

    tpe_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .clk (clk),
        .en  (en),
        .t0  (tot_x),
        .t1  (tot_y),
        .t2  (tot_z),
        .res (res)
    );

endmodule

### hdl/tpe_checker.sv
// Port-level checks of the trilinear evaluator and their binding.
`include "trilinear_poly_eval_and_rate_macros.svh"

module tpe_checker
    import tpe_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input tpe_res_t res
);

    logic sat_off_end;

    assign sat_off_end = res.saturated && (res.result != TPE_WORD_MAX)
                       && (res.result != TPE_WORD_MIN);

    // every accepted beat comes out after the fixed latency
    `TPE_ASSERT_IMP(a_lat_out, start && !busy, ##TPE_LATENCY done, "accepted beat not delivered")

    // no result without a beat accepted that far back
    `TPE_ASSERT_IMP(a_no_extra, done, $past(start && !busy, TPE_LATENCY), "result without beat")

    // a clipped result sits at one end of the word range
    `TPE_ASSERT_NEVER(a_sat_val, done && sat_off_end, "saturated result off range end")

endmodule

bind trilinear_poly_eval_and_rate tpe_checker u_tpe_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);
